### hdl/clamp_closure_test_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Clamp closure test sequencer: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CLAMP_CLOSURE_TEST_SEQUENCER_DEFINES_SVH
`define CLAMP_CLOSURE_TEST_SEQUENCER_DEFINES_SVH

// Same-cycle implication
`define CCTS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clamp closure sequencer: check failed");

// Next-cycle implication
`define CCTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clamp closure sequencer: check failed");

`endif

### hdl/ccts_pkg.sv
// ----------------------------------------------------------------------------
// Clamp closure test sequencer: package
// Item types, register indexes and fixed thresholds shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package ccts_pkg;

  // Fixed thresholds (pressure 0.1 mmHg, volume 0.01 ml, rate 0.1 ml/min)
  localparam logic signed [15:0] PRESS_FAIL     = 16'sd4000;
  localparam logic signed [15:0] PRESS_ZERO     = 16'sd0;
  localparam logic        [19:0] AC_RAISE_LIMIT = 20'd1000;
  localparam logic        [15:0] DRAIN_LIMIT    = 16'd4500;
  localparam logic        [15:0] DRAIN_SAT      = 16'hFFFF;
  localparam logic        [10:0] DRAIN_RATE     = 11'd300;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PASS_DELTA         = 3'd0,
    CFG_TEST_VOLUME_LIMIT  = 3'd1,
    CFG_INLET_TEST_RATE    = 3'd2,
    CFG_AC_TEST_RATE       = 3'd3,
    CFG_AC_PRESSURIZE_RATE = 3'd4,
    CFG_ALERT_RETRIES      = 3'd5
  } cfg_idx_e;

  // Input item kinds
  localparam logic KIND_START = 1'b0;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] pressure;
    logic        [19:0] ac_volume_total;
    logic        [19:0] inlet_volume_total;
    logic        [11:0] inlet_step_volume;
    logic               fluid_seen;
    logic               alert_clear;
    logic               alarm_clear;
    logic               meter_red_cells;
    logic               meter_platelets;
    logic               red_cells_ok;
    logic               resume_past_test;
  } item_t;

  typedef struct packed {
    logic [10:0] inlet_rate;
    logic [10:0] ac_rate;
    logic        fluid_alarm;
    logic        closure_alert;
    logic        closure_alarm;
    logic        continue_alarm;
    logic        disable_red_cells;
    logic        complete;
  } result_t;

  typedef struct packed {
    logic signed [15:0] pass_delta;
    logic        [19:0] test_volume_limit;
    logic        [10:0] inlet_test_rate;
    logic        [10:0] ac_test_rate;
    logic        [10:0] ac_pressurize_rate;
    logic        [1:0]  alert_retries;
  } cfg_t;

  // Settings after reset
  localparam cfg_t CFG_RESET = '{
    pass_delta:         16'sd0,
    test_volume_limit:  20'd2000,
    inlet_test_rate:    11'd0,
    ac_test_rate:       11'd0,
    ac_pressurize_rate: 11'd0,
    alert_retries:      2'd2
  };

  typedef struct packed {
    logic               pressure_raised;
    logic               pumping_down;
    logic               finish_pending;
    logic               final_alarm_done;
    logic        [1:0]  retry_count;
    logic signed [15:0] base_pressure;
    logic        [19:0] base_ac_volume;
    logic        [19:0] base_inlet_volume;
    logic        [15:0] drain_volume;
    logic        [10:0] cmd_inlet;
    logic        [10:0] cmd_ac;
  } state_t;

endpackage

`default_nettype wire

### hdl/ccts_step.sv
// ----------------------------------------------------------------------------
// Clamp closure test sequencer: step logic
// Next state and result for one item, from the current state and settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ccts_step import ccts_pkg::*; (
  input  item_t   item_i,
  input  state_t  st_i,
  input  cfg_t    cfg_i,
  output state_t  st_o,
  output result_t res_o
);

  logic signed [16:0] rise;
  logic        [19:0] ac_delta;
  logic        [19:0] in_delta;
  logic        [16:0] drain_sum;
  logic        [15:0] drain_new;
  logic               exit_now;
  logic               fluid_stop;

  // Differences; volume totals wrap so the 20-bit subtraction is exact
  assign rise      = $signed({item_i.pressure[15], item_i.pressure})
                   - $signed({st_i.base_pressure[15], st_i.base_pressure});
  assign ac_delta  = item_i.ac_volume_total - st_i.base_ac_volume;
  assign in_delta  = item_i.inlet_volume_total - st_i.base_inlet_volume;
  assign drain_sum = {1'b0, st_i.drain_volume} + {5'd0, item_i.inlet_step_volume};
  assign drain_new = drain_sum[16] ? DRAIN_SAT : drain_sum[15:0];
  assign exit_now  = st_i.finish_pending
                   || !(item_i.meter_red_cells && item_i.red_cells_ok)
                   || item_i.resume_past_test;

  always_comb begin
    st_o       = st_i;
    res_o      = '0;
    fluid_stop = 1'b0;

    if (item_i.kind == KIND_START) begin
      // Start of test: capture baselines only
      st_o.base_pressure     = item_i.pressure;
      st_o.base_ac_volume    = item_i.ac_volume_total;
      st_o.base_inlet_volume = item_i.inlet_volume_total;
    end else begin
      // Pump commands for the current phase
      if (!st_i.pumping_down) begin
        if (item_i.fluid_seen) begin
          res_o.fluid_alarm = 1'b1;
          fluid_stop        = 1'b1;
          st_o.cmd_ac       = '0;
          st_o.cmd_inlet    = '0;
        end else if (!st_i.pressure_raised) begin
          st_o.cmd_ac    = cfg_i.ac_pressurize_rate;
          st_o.cmd_inlet = '0;
        end else begin
          st_o.cmd_inlet = cfg_i.inlet_test_rate;
          st_o.cmd_ac    = cfg_i.ac_test_rate;
        end
      end else begin
        st_o.cmd_inlet = DRAIN_RATE;
      end

      if (exit_now) begin
        // Leave the test step with both pumps stopped
        res_o.complete      = 1'b1;
        st_o.finish_pending = 1'b0;
        st_o.cmd_inlet      = '0;
        st_o.cmd_ac         = '0;
      end else if (!fluid_stop) begin
        if (st_i.pumping_down) begin
          // Pump-down: ends on zero pressure or drained volume
          st_o.drain_volume = drain_new;
          if (item_i.pressure <= PRESS_ZERO || drain_new > DRAIN_LIMIT) begin
            st_o.drain_volume      = '0;
            st_o.pumping_down      = 1'b0;
            st_o.base_inlet_volume = item_i.inlet_volume_total;
            st_o.base_ac_volume    = item_i.ac_volume_total;
            if (st_i.retry_count < cfg_i.alert_retries) begin
              if (item_i.alert_clear) begin
                res_o.closure_alert = 1'b1;
                st_o.retry_count    = st_i.retry_count + 2'd1;
              end
            end else if (item_i.alarm_clear && !st_i.final_alarm_done) begin
              st_o.final_alarm_done = 1'b1;
              if (item_i.meter_red_cells && item_i.meter_platelets) begin
                res_o.continue_alarm    = 1'b1;
                res_o.disable_red_cells = 1'b1;
              end else begin
                res_o.closure_alarm = 1'b1;
              end
            end
          end
        end else if (!st_i.pressure_raised) begin
          // Pressurise: rebase once pressure is up or AC limit reached
          if (item_i.pressure > PRESS_ZERO || ac_delta > AC_RAISE_LIMIT) begin
            st_o.pressure_raised   = 1'b1;
            st_o.cmd_ac            = '0;
            st_o.cmd_inlet         = '0;
            st_o.base_pressure     = item_i.pressure;
            st_o.base_inlet_volume = item_i.inlet_volume_total;
            st_o.base_ac_volume    = item_i.ac_volume_total;
          end
        end else if (item_i.pressure > PRESS_FAIL) begin
          st_o.cmd_inlet    = '0;
          st_o.cmd_ac       = '0;
          st_o.pumping_down = 1'b1;
        end else if (rise <= $signed({cfg_i.pass_delta[15], cfg_i.pass_delta})) begin
          st_o.cmd_inlet      = '0;
          st_o.cmd_ac         = '0;
          st_o.finish_pending = 1'b1;
        end else if (in_delta >= cfg_i.test_volume_limit) begin
          st_o.cmd_inlet    = '0;
          st_o.cmd_ac       = '0;
          st_o.pumping_down = 1'b1;
        end
      end
    end

    res_o.inlet_rate = st_o.cmd_inlet;
    res_o.ac_rate    = st_o.cmd_ac;
  end

endmodule

`default_nettype wire

### hdl/clamp_closure_test_sequencer.sv
// ----------------------------------------------------------------------------
// Clamp closure test sequencer
// Runs the pump clamp closure test one control tick per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one item per
//   control tick: a start item captures baselines, a tick item runs a phase.
//   Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly
//   one result per item: held pump rates plus this tick's alert flags.
//   Settings are to be written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   only while the block is idle; the block itself does not enforce this.
//   Unknown indexes are ignored.
//   Timing: an accepted item is held in the input register, then its result
//   is registered into the output register once the output slot is free.
//   Throughput: one item per cycle while the output slot is free or being
//   drained, set by the combinational step logic that reads and updates the
//   test state between the two registers.
//   Stall: while out_ready_i is low the result holds and the input register
//   keeps one further item; input ready drops only when both are full.
//   Reset: all test state clears, settings return to their defaults and both
//   registers are emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module clamp_closure_test_sequencer import ccts_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  item_t                in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output result_t              out_data_o,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_wdata_i
);

`include "clamp_closure_test_sequencer_defines.svh"

  item_t   in_q;
  logic    in_valid_q;
  result_t out_q;
  logic    out_valid_q;
  state_t  st_q, st_d;
  cfg_t    cfg_q;
  result_t res_d;
  logic    advance;

  // Handshake: the item moves on whenever the result slot is free
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ccts_step u_step (
    .item_i (in_q),
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // Valid flags, test state and settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
      cfg_q       <= CFG_RESET;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PASS_DELTA:         cfg_q.pass_delta         <= cfg_wdata_i[15:0];
          CFG_TEST_VOLUME_LIMIT:  cfg_q.test_volume_limit  <= cfg_wdata_i;
          CFG_INLET_TEST_RATE:    cfg_q.inlet_test_rate    <= cfg_wdata_i[10:0];
          CFG_AC_TEST_RATE:       cfg_q.ac_test_rate       <= cfg_wdata_i[10:0];
          CFG_AC_PRESSURIZE_RATE: cfg_q.ac_pressurize_rate <= cfg_wdata_i[10:0];
          CFG_ALERT_RETRIES:      cfg_q.alert_retries      <= cfg_wdata_i[1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  // Checks
  `CCTS_ASSERT_IMPLY(a_complete_stops_pumps, out_valid_q && out_q.complete,
                     out_q.inlet_rate == '0 && out_q.ac_rate == '0)
  `CCTS_ASSERT_IMPLY(a_drain_excludes_finish, 1'b1,
                     !(st_q.pumping_down && st_q.finish_pending))
  `CCTS_ASSERT_IMPLY(a_final_alarm_once, advance && (res_d.closure_alarm || res_d.continue_alarm),
                     !st_q.final_alarm_done)
  `CCTS_ASSERT_NEXT(a_retry_needs_alert, advance && st_d.retry_count != st_q.retry_count,
                    out_q.closure_alert)

endmodule

`default_nettype wire
